>>> rtl/bgi_pkg.sv
// Shared types and constants for the bilinear grid interpolator.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package bgi_pkg;

   localparam int MAX_X_POINTS = 16;
   localparam int MAX_Y_POINTS = 16;
   localparam int XIW = $clog2(MAX_X_POINTS);
   localparam int YIW = $clog2(MAX_Y_POINTS);
   localparam int CNT_W = 5;
   localparam int QW = 16;
   localparam int FW = QW + 1;
   localparam logic [FW-1:0] FRAC_ONE = FW'(1) << QW;
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QW);

   localparam logic [1:0] CMD_WR_X = 2'd0;
   localparam logic [1:0] CMD_WR_Y = 2'd1;
   localparam logic [1:0] CMD_WR_CELL = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef struct packed {
      logic       write_en;
      logic       load;
      logic       axis;
      logic [4:0] rd_idx;
      logic       scan_proc;
      logic       scan_first;
      logic       scan_last;
      logic [4:0] proc_idx;
      logic       div_init;
      logic       div_step;
      logic       div_last;
      logic [1:0] cell_sel;
      logic       cell_cap;
      logic [1:0] cap_sel;
      logic [2:0] mul_sel;
      logic       acc;
      logic [2:0] acc_sel;
   } dp_cmd_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxn);
      logic [CNT_W-1:0] n;
      n = v;
      if (n == '0) n = CNT_W'(1);
      if (n > maxn) n = maxn;
      return n;
   endfunction

endpackage

`default_nettype wire

>>> rtl/bgi_datapath.sv
// Datapath: axis and grid memories, neighbor scan, serial fraction divider
// and shared blend multiplier. Driven by bgi_ctrl commands; uses bgi_pkg.
`default_nettype none

module bgi_datapath (
   input  wire logic                clock,
   input  wire bgi_pkg::dp_cmd_type cmd,
   input  wire logic [1:0]          command,
   input  wire logic [3:0]          row_index,
   input  wire logic [3:0]          col_index,
   input  wire logic signed [31:0]  write_value,
   input  wire logic signed [31:0]  query_x,
   input  wire logic signed [31:0]  query_y,
   output logic signed [31:0]       result
);
   import bgi_pkg::*;

   logic signed [31:0] xmem [MAX_X_POINTS];
   logic signed [31:0] ymem [MAX_Y_POINTS];
   logic signed [31:0] gmem [MAX_X_POINTS*MAX_Y_POINTS];

   logic signed [31:0] xrd_ff, yrd_ff, grd_ff;
   logic signed [31:0] qx_ff, qy_ff;
   logic [XIW-1:0] xlo_ff, xhi_ff;
   logic [YIW-1:0] ylo_ff, yhi_ff;
   logic [3:0] lo_idx_ff, lo_idx_in, hi_idx_ff, hi_idx_in;
   logic signed [31:0] lo_val_ff, lo_val_in, hi_val_ff, hi_val_in;
   logic found_ff, found_in, found_cur;
   logic signed [31:0] pt, coord;

   logic signed [32:0] num, den;
   logic [32:0] an, ad;
   logic [33:0] rem_ff, rem_in, r2;
   logic [32:0] den_ff;
   logic [QW-1:0] q_ff, q_in;
   logic zero_ff, sat_ff, ge;
   logic [FW-1:0] fx_ff, fy_ff, frac;

   logic [XIW-1:0] cx;
   logic [YIW-1:0] cy;
   logic signed [31:0] cell_ff [4];
   logic signed [31:0] c0_ff, c1_ff, result_ff;
   logic signed [31:0] op_a;
   logic [FW-1:0] fsel, wgt;
   logic signed [49:0] prod_ff, acc_ff;
   logic signed [50:0] sum;
   logic signed [31:0] blend_val;

   assign pt    = (cmd.axis == AXIS_Y) ? yrd_ff : xrd_ff;
   assign coord = (cmd.axis == AXIS_Y) ? qy_ff : qx_ff;

   always_comb begin
      found_cur = cmd.scan_first ? 1'b0 : found_ff;
      lo_idx_in = lo_idx_ff;
      lo_val_in = lo_val_ff;
      hi_idx_in = hi_idx_ff;
      hi_val_in = hi_val_ff;
      found_in  = found_cur;
      if (cmd.scan_first) begin
         lo_idx_in = '0;
         lo_val_in = pt;
      end
      if (pt <= coord) begin
         lo_idx_in = cmd.proc_idx[3:0];
         lo_val_in = pt;
      end
      if (!found_cur && (pt >= coord || cmd.scan_last)) begin
         hi_idx_in = cmd.proc_idx[3:0];
         hi_val_in = pt;
         found_in  = 1'b1;
      end
   end

   always_comb begin
      num = {coord[31], coord} - {lo_val_ff[31], lo_val_ff};
      den = {hi_val_ff[31], hi_val_ff} - {lo_val_ff[31], lo_val_ff};
      an  = num[32] ? 33'(-num) : 33'(num);
      ad  = den[32] ? 33'(-den) : 33'(den);
      r2  = {rem_ff[32:0], 1'b0};
      ge  = r2 >= {1'b0, den_ff};
      rem_in = ge ? (r2 - {1'b0, den_ff}) : r2;
      q_in = {q_ff[QW-2:0], ge};
      if (zero_ff) frac = '0;
      else if (sat_ff) frac = FRAC_ONE;
      else frac = {1'b0, q_in};
   end

   assign cy = cmd.cell_sel[1] ? yhi_ff : ylo_ff;
   assign cx = cmd.cell_sel[0] ? xhi_ff : xlo_ff;

   always_comb begin
      unique case (cmd.mul_sel)
         3'd0: op_a = cell_ff[0];
         3'd1: op_a = cell_ff[1];
         3'd2: op_a = cell_ff[2];
         3'd3: op_a = cell_ff[3];
         3'd4: op_a = c0_ff;
         default: op_a = c1_ff;
      endcase
      fsel = cmd.mul_sel[2] ? fy_ff : fx_ff;
      wgt  = cmd.mul_sel[0] ? fsel : (FRAC_ONE - fsel);
      sum  = {acc_ff[49], acc_ff} + {prod_ff[49], prod_ff};
      blend_val = sum[47:16];
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         unique case (command)
            CMD_WR_X:    xmem[col_index] <= write_value;
            CMD_WR_Y:    ymem[row_index] <= write_value;
            CMD_WR_CELL: gmem[{row_index, col_index}] <= write_value;
            default: ;
         endcase
      end
      xrd_ff <= xmem[cmd.rd_idx[XIW-1:0]];
      yrd_ff <= ymem[cmd.rd_idx[YIW-1:0]];
      grd_ff <= gmem[{cy, cx}];
      if (cmd.load) begin
         qx_ff <= query_x;
         qy_ff <= query_y;
      end
      if (cmd.scan_proc) begin
         lo_idx_ff <= lo_idx_in;
         lo_val_ff <= lo_val_in;
         hi_idx_ff <= hi_idx_in;
         hi_val_ff <= hi_val_in;
         found_ff  <= found_in;
      end
      if (cmd.div_init) begin
         rem_ff  <= {1'b0, an};
         den_ff  <= ad;
         q_ff    <= '0;
         zero_ff <= (lo_val_ff == hi_val_ff) || (num[32] != den[32]);
         sat_ff  <= an >= ad;
         if (cmd.axis == AXIS_Y) begin
            ylo_ff <= lo_idx_ff[YIW-1:0];
            yhi_ff <= hi_idx_ff[YIW-1:0];
         end else begin
            xlo_ff <= lo_idx_ff[XIW-1:0];
            xhi_ff <= hi_idx_ff[XIW-1:0];
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
         if (cmd.div_last) begin
            if (cmd.axis == AXIS_Y) fy_ff <= frac;
            else fx_ff <= frac;
         end
      end
      if (cmd.cell_cap) cell_ff[cmd.cap_sel] <= grd_ff;
      prod_ff <= op_a * $signed({1'b0, wgt});
      if (cmd.acc) begin
         if (!cmd.acc_sel[0]) acc_ff <= prod_ff;
         else begin
            unique case (cmd.acc_sel[2:1])
               2'd0: c0_ff <= blend_val;
               2'd1: c1_ff <= blend_val;
               default: result_ff <= blend_val;
            endcase
         end
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

>>> rtl/bgi_ctrl.sv
// Query sequencer: scan, divide, cell fetch and blend phases.
// Issues bgi_pkg::dp_cmd_type commands to bgi_datapath; uses bgi_pkg.
`default_nettype none

module bgi_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [1:0]                   command,
   input  wire logic [bgi_pkg::CNT_W-1:0]    x_count,
   input  wire logic [bgi_pkg::CNT_W-1:0]    y_count,
   output logic                              busy,
   output logic                              strobe,
   output bgi_pkg::dp_cmd_type               cmd
);
   import bgi_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_XSCAN = 3'd1;
   localparam logic [2:0] S_XDIV  = 3'd2;
   localparam logic [2:0] S_YSCAN = 3'd3;
   localparam logic [2:0] S_YDIV  = 3'd4;
   localparam logic [2:0] S_CELL  = 3'd5;
   localparam logic [2:0] S_BLEND = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, n_sel, cnt_m1;

   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign n_sel  = (state_ff == S_YSCAN) ? y_count : x_count;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      cmd = '0;
      cmd.rd_idx   = cnt_ff;
      cmd.proc_idx = cnt_m1;
      cmd.cell_sel = cnt_ff[1:0];
      cmd.cap_sel  = cnt_m1[1:0];
      cmd.mul_sel  = cnt_ff[2:0];
      cmd.acc_sel  = cnt_m1[2:0];
      cmd.axis = (state_ff == S_YSCAN || state_ff == S_YDIV) ? AXIS_Y : AXIS_X;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (start) begin
               if (command == CMD_QUERY) begin
                  cmd.load = 1'b1;
                  state_in = S_XSCAN;
               end else cmd.write_en = 1'b1;
            end
         end
         S_XSCAN, S_YSCAN: begin
            cmd.scan_proc  = cnt_ff != '0;
            cmd.scan_first = cnt_ff == CNT_W'(1);
            cmd.scan_last  = cnt_ff == n_sel;
            if (cnt_ff == n_sel) begin
               cnt_in = '0;
               state_in = (state_ff == S_XSCAN) ? S_XDIV : S_YDIV;
            end
         end
         S_XDIV, S_YDIV: begin
            cmd.div_init = cnt_ff == '0;
            cmd.div_step = cnt_ff != '0;
            cmd.div_last = cnt_ff == DIV_LAST;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               state_in = (state_ff == S_XDIV) ? S_YSCAN : S_CELL;
            end
         end
         S_CELL: begin
            cmd.cell_cap = cnt_ff != '0;
            if (cnt_ff == CNT_W'(4)) begin
               cnt_in = '0;
               state_in = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.acc = cnt_ff != '0;
            if (cnt_ff == CNT_W'(6)) begin
               cnt_in = '0;
               state_in = S_DONE;
            end
         end
         default: begin
            cnt_in = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign busy   = state_ff != S_IDLE;
   assign strobe = state_ff == S_DONE;

   a_query_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && command == CMD_QUERY) |=> busy)
      else $error("query not started");
   a_write_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && command != CMD_QUERY) |=> !busy)
      else $error("write left idle");
   a_strobe_then_idle: assert property (@(posedge clock) disable iff (reset)
      strobe |=> !busy && !strobe)
      else $error("result not single cycle");
   a_strobe_after_blend: assert property (@(posedge clock) disable iff (reset)
      strobe |-> $past(state_ff) == S_BLEND)
      else $error("result without blend");

endmodule

`default_nettype wire

>>> rtl/bilinear_grid_interpolator.sv
// Top level: configuration registers, sequencer and datapath.
// Instantiates bgi_ctrl and bgi_datapath; uses bgi_pkg.
`default_nettype none

// A request is taken when start is high and busy is low. Writes of axis
// points and grid cells return nothing. A query holds busy up to and including
// the cycle that shows its value with rsp_strobe for one cycle, which the
// receiver cannot stall; the next request may be taken in the cycle after.
// A query runs the one-point-per-cycle axis scans, the 16-step fraction
// divider run once per axis, four grid memory reads and six passes through
// one shared multiplier.
// Memories hold no reset value; query only over written points and cells.
module bilinear_grid_interpolator (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_command,
   input  wire logic [3:0]         req_row_index,
   input  wire logic [3:0]         req_col_index,
   input  wire logic signed [31:0] req_write_value,
   input  wire logic signed [31:0] req_query_x,
   input  wire logic signed [31:0] req_query_y,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_interpolated_value,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [2:0]         paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   import bgi_pkg::*;

   logic [CNT_W-1:0] x_cnt_ff, y_cnt_ff;
   dp_cmd_type cmd;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_cnt_ff <= CNT_W'(MAX_X_POINTS);
         y_cnt_ff <= CNT_W'(MAX_Y_POINTS);
      end else if (psel && penable && pwrite) begin
         if (!paddr[2]) x_cnt_ff <= clamp_count(pwdata[CNT_W-1:0], CNT_W'(MAX_X_POINTS));
         else y_cnt_ff <= clamp_count(pwdata[CNT_W-1:0], CNT_W'(MAX_Y_POINTS));
      end
   end

   assign prdata = {27'b0, paddr[2] ? y_cnt_ff : x_cnt_ff};

   bgi_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .x_count (x_cnt_ff),
      .y_count (y_cnt_ff),
      .busy    (busy),
      .strobe  (rsp_strobe),
      .cmd     (cmd)
   );

   bgi_datapath u_dp (
      .clock       (clock),
      .cmd         (cmd),
      .command     (req_command),
      .row_index   (req_row_index),
      .col_index   (req_col_index),
      .write_value (req_write_value),
      .query_x     (req_query_x),
      .query_y     (req_query_y),
      .result      (rsp_interpolated_value)
   );

endmodule

`default_nettype wire
